FILE: design/owtr_pkg.sv
// shared types, constants and tables for the 1-wire temperature reader
package owtr_pkg;

  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_TAIL      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_LOW       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONG_LOW        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SLOT            = 3'd6;

  localparam logic [9:0] RST_RESET_LOW       = 10'd480;
  localparam logic [7:0] RST_PRESENCE_SAMPLE = 8'd70;
  localparam logic [9:0] RST_RESET_TAIL      = 10'd410;
  localparam logic [5:0] RST_SHORT_LOW       = 6'd6;
  localparam logic [6:0] RST_LONG_LOW        = 7'd60;
  localparam logic [6:0] RST_READ_SAMPLE     = 7'd15;
  localparam logic [6:0] RST_SLOT            = 7'd70;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_RST_LOW   = 9'b000000010,
    PH_RST_WAIT  = 9'b000000100,
    PH_RST_TAIL  = 9'b000001000,
    PH_WSLOT     = 9'b000010000,
    PH_RSLOT     = 9'b000100000,
    PH_FRST_LOW  = 9'b001000000,
    PH_FRST_WAIT = 9'b010000000,
    PH_FRST_TAIL = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [7:0] presence_sample_us;
    logic [9:0] reset_tail_us;
    logic [5:0] short_low_us;
    logic [6:0] long_low_us;
    logic [6:0] read_sample_us;
    logic [6:0] slot_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       present;
    logic       negative;
    logic [6:0] whole_degrees;
    logic [3:0] tenths;
  } result_t;

  typedef struct packed {
    logic       negative;
    logic [6:0] whole_degrees;
    logic [3:0] tenths;
  } temp_t;

  // first decimal digit of a sixteenth of a degree
  function automatic logic [3:0] tenths_lut(input logic [3:0] frac);
    logic [3:0] d;
    case (frac)
      4'd0:    d = 4'd0;
      4'd1:    d = 4'd0;
      4'd2:    d = 4'd1;
      4'd3:    d = 4'd1;
      4'd4:    d = 4'd2;
      4'd5:    d = 4'd3;
      4'd6:    d = 4'd3;
      4'd7:    d = 4'd4;
      4'd8:    d = 4'd5;
      4'd9:    d = 4'd5;
      4'd10:   d = 4'd6;
      4'd11:   d = 4'd6;
      4'd12:   d = 4'd7;
      4'd13:   d = 4'd8;
      4'd14:   d = 4'd8;
      default: d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

FILE: design/owtr_decode.sv
// decodes the scratchpad temperature word into sign, degrees and tenths
module owtr_decode (
  input  logic [15:0]         word,
  output owtr_pkg::temp_t     temp
);

  logic        neg;
  logic [15:0] mag;

  assign neg = word[15];
  assign mag = neg ? (~word + 16'd1) : word;

  assign temp.negative      = neg;
  assign temp.whole_degrees = mag[10:4];
  assign temp.tenths        = owtr_pkg::tenths_lut(mag[3:0]);

endmodule

FILE: design/owtr_seq.sv
// bus sequencer: phase state, slot timing, bit shifting and held temperature
module owtr_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  owtr_pkg::cfg_t       cfg,
  input  logic                 start_req,
  input  logic                 func,
  input  logic                 line_level,
  output owtr_pkg::result_t    res
);

  owtr_pkg::phase_t phase_r, phase_nxt, ph;
  logic [10:0] us_count_r, us_count_nxt, cnt;
  logic [2:0]  bit_index_r, bit_index_nxt, bi;
  logic [1:0]  byte_index_r, byte_index_nxt, byi, by1;
  logic [15:0] shift_word_r, shift_word_nxt, sw;
  logic        operation_r, op;
  logic        present_r, present_nxt;
  owtr_pkg::temp_t held_r, dec_temp;
  logic        dec_en;

  logic [9:0]  rl_len, tail_len;
  logic [7:0]  wait_len;
  logic [5:0]  short_eff;
  logic [6:0]  long_eff, wlow, wlen, rlen, rsamp;
  logic [7:0]  cmd;
  logic        wbit;
  logic [10:0] len_sel;
  logic [11:0] cnt_inc;
  logic        end_hit;
  logic [10:0] cnt_adv;
  logic        drive, busy, done;

  assign rl_len    = (cfg.reset_low_us == 10'd0) ? 10'd1 : cfg.reset_low_us;
  assign wait_len  = (cfg.presence_sample_us == 8'd0) ? 8'd1 : cfg.presence_sample_us;
  assign tail_len  = (cfg.reset_tail_us == 10'd0) ? 10'd1 : cfg.reset_tail_us;
  assign short_eff = (cfg.short_low_us == 6'd0) ? 6'd1 : cfg.short_low_us;
  assign long_eff  = (cfg.long_low_us == 7'd0) ? 7'd1 : cfg.long_low_us;

  // start folds into the first reset-low tick
  always_comb begin
    ph  = phase_r;
    cnt = us_count_r;
    bi  = bit_index_r;
    byi = byte_index_r;
    sw  = shift_word_r;
    op  = operation_r;
    if (phase_r == owtr_pkg::PH_IDLE && start_req) begin
      ph  = owtr_pkg::PH_RST_LOW;
      cnt = 11'd0;
      bi  = 3'd0;
      byi = 2'd0;
      sw  = 16'd0;
      op  = func;
    end
  end

  assign cmd   = (byi == 2'd0) ? owtr_pkg::CMD_SKIP_ROM
               : (op ? owtr_pkg::CMD_READ_PAD : owtr_pkg::CMD_CONVERT);
  assign wbit  = cmd[bi];
  assign wlow  = wbit ? {1'b0, short_eff} : long_eff;
  assign wlen  = (cfg.slot_us > wlow) ? cfg.slot_us : wlow;
  assign rlen  = (cfg.slot_us > {1'b0, short_eff}) ? cfg.slot_us : {1'b0, short_eff};
  assign rsamp = (cfg.read_sample_us < rlen) ? cfg.read_sample_us : (rlen - 7'd1);
  assign by1   = byi + 2'd1;

  always_comb begin
    case (ph)
      owtr_pkg::PH_RST_LOW,
      owtr_pkg::PH_FRST_LOW:  len_sel = {1'b0, rl_len};
      owtr_pkg::PH_RST_WAIT,
      owtr_pkg::PH_FRST_WAIT: len_sel = {3'd0, wait_len};
      owtr_pkg::PH_RST_TAIL,
      owtr_pkg::PH_FRST_TAIL: len_sel = {1'b0, tail_len};
      owtr_pkg::PH_WSLOT:     len_sel = {4'd0, wlen};
      owtr_pkg::PH_RSLOT:     len_sel = {4'd0, rlen};
      default:                len_sel = 11'd1;
    endcase
  end

  assign cnt_inc = {1'b0, cnt} + 12'd1;
  assign end_hit = cnt_inc >= {1'b0, len_sel};
  assign cnt_adv = end_hit ? 11'd0 : cnt_inc[10:0];

  always_comb begin
    phase_nxt      = ph;
    us_count_nxt   = cnt_adv;
    bit_index_nxt  = bi;
    byte_index_nxt = byi;
    shift_word_nxt = sw;
    present_nxt    = present_r;
    dec_en         = 1'b0;
    drive          = 1'b0;
    busy           = 1'b1;
    done           = 1'b0;
    case (ph)
      owtr_pkg::PH_IDLE: begin
        busy         = 1'b0;
        us_count_nxt = cnt;
      end
      owtr_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        if (end_hit) phase_nxt = owtr_pkg::PH_RST_WAIT;
      end
      owtr_pkg::PH_FRST_LOW: begin
        drive = 1'b1;
        if (end_hit) phase_nxt = owtr_pkg::PH_FRST_WAIT;
      end
      owtr_pkg::PH_RST_WAIT: begin
        if (end_hit) phase_nxt = owtr_pkg::PH_RST_TAIL;
      end
      owtr_pkg::PH_FRST_WAIT: begin
        if (end_hit) phase_nxt = owtr_pkg::PH_FRST_TAIL;
      end
      owtr_pkg::PH_RST_TAIL: begin
        if (cnt == 11'd0) present_nxt = ~line_level;
        if (end_hit) begin
          if (present_nxt) begin
            phase_nxt      = owtr_pkg::PH_WSLOT;
            bit_index_nxt  = 3'd0;
            byte_index_nxt = 2'd0;
          end else begin
            phase_nxt = owtr_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      owtr_pkg::PH_FRST_TAIL: begin
        if (end_hit) begin
          dec_en    = 1'b1;
          phase_nxt = owtr_pkg::PH_IDLE;
          done      = 1'b1;
        end
      end
      owtr_pkg::PH_WSLOT: begin
        drive = cnt < {4'd0, wlow};
        if (end_hit) begin
          if (bi == 3'd7) begin
            bit_index_nxt  = 3'd0;
            byte_index_nxt = by1;
            if (by1 >= 2'd2) begin
              if (op) begin
                phase_nxt = owtr_pkg::PH_RSLOT;
              end else begin
                phase_nxt = owtr_pkg::PH_IDLE;
                done      = 1'b1;
              end
            end
          end else begin
            bit_index_nxt = bi + 3'd1;
          end
        end
      end
      owtr_pkg::PH_RSLOT: begin
        drive = cnt < {5'd0, short_eff};
        if (cnt == {4'd0, rsamp}) shift_word_nxt = {line_level, sw[15:1]};
        if (end_hit) begin
          if (bi == 3'd7) begin
            bit_index_nxt = 3'd0;
            if (byi == 2'd3) begin
              phase_nxt      = owtr_pkg::PH_FRST_LOW;
              byte_index_nxt = 2'd0;
            end else begin
              byte_index_nxt = by1;
            end
          end else begin
            bit_index_nxt = bi + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = owtr_pkg::PH_IDLE;
        done      = 1'b1;
      end
    endcase
  end

  owtr_decode u_decode (
    .word (sw),
    .temp (dec_temp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owtr_pkg::PH_IDLE;
      us_count_r   <= 11'd0;
      bit_index_r  <= 3'd0;
      byte_index_r <= 2'd0;
      shift_word_r <= 16'd0;
      operation_r  <= 1'b0;
      present_r    <= 1'b0;
      held_r       <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      us_count_r   <= us_count_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      shift_word_r <= shift_word_nxt;
      operation_r  <= op;
      present_r    <= present_nxt;
      if (dec_en) held_r <= dec_temp;
    end
  end

  always_comb begin
    res.drive_low     = drive;
    res.busy_res      = busy;
    res.done_res      = done;
    res.present       = present_nxt;
    res.negative      = dec_en ? dec_temp.negative      : held_r.negative;
    res.whole_degrees = dec_en ? dec_temp.whole_degrees : held_r.whole_degrees;
    res.tenths        = dec_en ? dec_temp.tenths        : held_r.tenths;
  end

endmodule

FILE: design/onewire_temp_sensor_reader_unit.sv
// top level: input register, timing registers, sequencer and result register
// a word goes through the input register, its result through the result register
// throughput: one word per cycle; the sequencer steps once per input register load
// stalls on the result side hold the input register and the sequencer state
// reset (rst_n low, synchronous): sequencer idle, held temperature zero,
// timing registers at their defaults, both registers empty
module onewire_temp_sensor_reader_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_start_req,
  input  logic                            in_func,
  input  logic                            in_line_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_low,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_present,
  output logic                            out_negative,
  output logic [6:0]                      out_whole_degrees,
  output logic [3:0]                      out_tenths,
  input  logic                            cfg_we,
  input  logic [owtr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [owtr_pkg::CfgDataW-1:0]   cfg_data
);

  owtr_pkg::cfg_t    cfg_r;
  owtr_pkg::result_t seq_res, res_r;
  logic in_valid_r, out_valid_r, out_valid_nxt;
  logic start_r, func_r, line_r;
  logic step_en;

  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us       <= owtr_pkg::RST_RESET_LOW;
      cfg_r.presence_sample_us <= owtr_pkg::RST_PRESENCE_SAMPLE;
      cfg_r.reset_tail_us      <= owtr_pkg::RST_RESET_TAIL;
      cfg_r.short_low_us       <= owtr_pkg::RST_SHORT_LOW;
      cfg_r.long_low_us        <= owtr_pkg::RST_LONG_LOW;
      cfg_r.read_sample_us     <= owtr_pkg::RST_READ_SAMPLE;
      cfg_r.slot_us            <= owtr_pkg::RST_SLOT;
    end else if (cfg_we) begin
      case (cfg_index)
        owtr_pkg::CFG_RESET_LOW:       cfg_r.reset_low_us       <= cfg_data;
        owtr_pkg::CFG_PRESENCE_SAMPLE: cfg_r.presence_sample_us <= cfg_data[7:0];
        owtr_pkg::CFG_RESET_TAIL:      cfg_r.reset_tail_us      <= cfg_data;
        owtr_pkg::CFG_SHORT_LOW:       cfg_r.short_low_us       <= cfg_data[5:0];
        owtr_pkg::CFG_LONG_LOW:        cfg_r.long_low_us        <= cfg_data[6:0];
        owtr_pkg::CFG_READ_SAMPLE:     cfg_r.read_sample_us     <= cfg_data[6:0];
        owtr_pkg::CFG_SLOT:            cfg_r.slot_us            <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      start_r <= in_start_req;
      func_r  <= in_func;
      line_r  <= in_line_level;
    end
  end

  owtr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .cfg        (cfg_r),
    .start_req  (start_r),
    .func       (func_r),
    .line_level (line_r),
    .res        (seq_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) res_r <= seq_res;
  end

  assign out_valid         = out_valid_r;
  assign out_drive_low     = res_r.drive_low;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_present       = res_r.present;
  assign out_negative      = res_r.negative;
  assign out_whole_degrees = res_r.whole_degrees;
  assign out_tenths        = res_r.tenths;

endmodule

FILE: design/owtr_checker.sv
// port-level checks for the 1-wire temperature reader, bound to the top level
module owtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_drive_low,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [3:0] out_tenths
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_low)
      && $stable(out_busy_res) && $stable(out_done_res) && $stable(out_tenths))
    else $error("stalled result word changed");

  // empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res)
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("bus driven while idle");

  a_tenths_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tenths <= 4'd9)
    else $error("tenths not a decimal digit");

endmodule

bind onewire_temp_sensor_reader_unit owtr_checker u_owtr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_drive_low (out_drive_low),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_tenths    (out_tenths)
);

FILE: bench/owtr_status_checker.sv
// checker for the 1-wire temperature reader: bus tick predictor and result word compare
`timescale 1ns / 100ps

module owtr_status_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_start_req,
  input  logic                          in_func,
  input  logic                          in_line_level,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_drive_low,
  input  logic                          out_busy_res,
  input  logic                          out_done_res,
  input  logic                          out_present,
  input  logic                          out_negative,
  input  logic [6:0]                    out_whole_degrees,
  input  logic [3:0]                    out_tenths,
  input  logic                          cfg_we,
  input  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [owtr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          run_done,
  output int                            mismatches,
  output int                            words_checked,
  output int                            seq_done
);

  owtr_pkg::phase_t  ph;
  logic [10:0]       tick_cnt;
  logic [2:0]        bit_pos;
  logic [1:0]        byte_pos;
  logic [15:0]       rx_word;
  logic              op_read;
  logic              presence;
  owtr_pkg::temp_t   held;
  owtr_pkg::cfg_t    timing;
  owtr_pkg::result_t status_q[$];
  owtr_pkg::result_t exp_w;
  owtr_pkg::result_t got_w;
  bit                leftover_checked;

  function automatic int nonzero_len(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  // advance the tick counter, true on the last tick of the current step
  function automatic bit slot_over(input int len);
    if (int'(tick_cnt) + 1 >= len) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt + 11'd1;
    return 1'b0;
  endfunction

  task automatic decode_scratchpad();
    logic [15:0] mag;
    mag = rx_word[15] ? (~rx_word + 16'd1) : rx_word;
    held.negative      = rx_word[15];
    held.whole_degrees = mag[10:4];
    held.tenths        = 4'((int'(mag[3:0]) * 625) / 1000);
  endtask

  task automatic predict_bus_tick(input logic start, input logic func, input logic line,
                                  output owtr_pkg::result_t r);
    int         low;
    int         len;
    int         smp;
    logic [7:0] cmd;
    r = '0;
    if (ph == owtr_pkg::PH_IDLE && start) begin
      op_read  = func;
      ph       = owtr_pkg::PH_RST_LOW;
      tick_cnt = '0;
      bit_pos  = '0;
      byte_pos = '0;
      rx_word  = '0;
    end
    if (ph != owtr_pkg::PH_IDLE) begin
      r.busy_res = 1'b1;
      case (ph)
        owtr_pkg::PH_RST_LOW, owtr_pkg::PH_FRST_LOW: begin
          r.drive_low = 1'b1;
          if (slot_over(nonzero_len(int'(timing.reset_low_us))))
            ph = (ph == owtr_pkg::PH_RST_LOW) ? owtr_pkg::PH_RST_WAIT : owtr_pkg::PH_FRST_WAIT;
        end
        owtr_pkg::PH_RST_WAIT, owtr_pkg::PH_FRST_WAIT: begin
          if (slot_over(nonzero_len(int'(timing.presence_sample_us))))
            ph = (ph == owtr_pkg::PH_RST_WAIT) ? owtr_pkg::PH_RST_TAIL : owtr_pkg::PH_FRST_TAIL;
        end
        owtr_pkg::PH_RST_TAIL: begin
          if (tick_cnt == 0) presence = ~line;
          if (slot_over(nonzero_len(int'(timing.reset_tail_us)))) begin
            if (presence) begin
              ph       = owtr_pkg::PH_WSLOT;
              bit_pos  = '0;
              byte_pos = '0;
            end else begin
              ph         = owtr_pkg::PH_IDLE;
              r.done_res = 1'b1;
            end
          end
        end
        owtr_pkg::PH_FRST_TAIL: begin
          if (slot_over(nonzero_len(int'(timing.reset_tail_us)))) begin
            decode_scratchpad();
            ph         = owtr_pkg::PH_IDLE;
            r.done_res = 1'b1;
          end
        end
        owtr_pkg::PH_WSLOT: begin
          cmd = (byte_pos == 0) ? owtr_pkg::CMD_SKIP_ROM
              : (op_read ? owtr_pkg::CMD_READ_PAD : owtr_pkg::CMD_CONVERT);
          low = nonzero_len(cmd[bit_pos] ? int'(timing.short_low_us)
                                         : int'(timing.long_low_us));
          len = (int'(timing.slot_us) > low) ? int'(timing.slot_us) : low;
          r.drive_low = (int'(tick_cnt) < low);
          if (slot_over(len)) begin
            if (bit_pos == 3'd7) begin
              bit_pos  = '0;
              byte_pos = byte_pos + 2'd1;
              if (byte_pos >= 2) begin
                if (op_read) begin
                  ph = owtr_pkg::PH_RSLOT;
                end else begin
                  ph         = owtr_pkg::PH_IDLE;
                  r.done_res = 1'b1;
                end
              end
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
        owtr_pkg::PH_RSLOT: begin
          low = nonzero_len(int'(timing.short_low_us));
          len = (int'(timing.slot_us) > low) ? int'(timing.slot_us) : low;
          smp = (int'(timing.read_sample_us) < len) ? int'(timing.read_sample_us) : len - 1;
          r.drive_low = (int'(tick_cnt) < low);
          if (int'(tick_cnt) == smp) rx_word = {line, rx_word[15:1]};
          if (slot_over(len)) begin
            if (bit_pos == 3'd7) begin
              bit_pos = '0;
              if (byte_pos == 2'd3) begin
                ph       = owtr_pkg::PH_FRST_LOW;
                byte_pos = '0;
              end else begin
                byte_pos = byte_pos + 2'd1;
              end
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
        default: begin
          ph         = owtr_pkg::PH_IDLE;
          r.done_res = 1'b1;
        end
      endcase
    end
    r.present       = presence;
    r.negative      = held.negative;
    r.whole_degrees = held.whole_degrees;
    r.tenths        = held.tenths;
  endtask

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [6:0] e, input logic [6:0] g);
    if (g !== e)
      report_error($sformatf("word %0d %s: expected %0d got %0d", words_checked, name, e, g));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph               = owtr_pkg::PH_IDLE;
      tick_cnt         = '0;
      bit_pos          = '0;
      byte_pos         = '0;
      rx_word          = '0;
      op_read          = 1'b0;
      presence         = 1'b0;
      held             = '0;
      timing           = '{reset_low_us: owtr_pkg::RST_RESET_LOW,
                           presence_sample_us: owtr_pkg::RST_PRESENCE_SAMPLE,
                           reset_tail_us: owtr_pkg::RST_RESET_TAIL,
                           short_low_us: owtr_pkg::RST_SHORT_LOW,
                           long_low_us: owtr_pkg::RST_LONG_LOW,
                           read_sample_us: owtr_pkg::RST_READ_SAMPLE,
                           slot_us: owtr_pkg::RST_SLOT};
      status_q.delete();
      leftover_checked = 1'b0;
      mismatches       = 0;
      words_checked    = 0;
      seq_done         = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          owtr_pkg::CFG_RESET_LOW:       timing.reset_low_us       = cfg_data;
          owtr_pkg::CFG_PRESENCE_SAMPLE: timing.presence_sample_us = cfg_data[7:0];
          owtr_pkg::CFG_RESET_TAIL:      timing.reset_tail_us      = cfg_data;
          owtr_pkg::CFG_SHORT_LOW:       timing.short_low_us       = cfg_data[5:0];
          owtr_pkg::CFG_LONG_LOW:        timing.long_low_us        = cfg_data[6:0];
          owtr_pkg::CFG_READ_SAMPLE:     timing.read_sample_us     = cfg_data[6:0];
          owtr_pkg::CFG_SLOT:            timing.slot_us            = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_bus_tick(in_start_req, in_func, in_line_level, exp_w);
        status_q.push_back(exp_w);
      end
      if (out_valid && out_ready) begin
        got_w = {out_drive_low, out_busy_res, out_done_res, out_present, out_negative,
                 out_whole_degrees, out_tenths};
        if (status_q.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          exp_w = status_q.pop_front();
          check_field("drive_low", 7'(exp_w.drive_low), 7'(got_w.drive_low));
          check_field("busy_res", 7'(exp_w.busy_res), 7'(got_w.busy_res));
          check_field("done_res", 7'(exp_w.done_res), 7'(got_w.done_res));
          check_field("present", 7'(exp_w.present), 7'(got_w.present));
          check_field("negative", 7'(exp_w.negative), 7'(got_w.negative));
          check_field("whole_degrees", exp_w.whole_degrees, got_w.whole_degrees);
          check_field("tenths", 7'(exp_w.tenths), 7'(got_w.tenths));
          if (exp_w.done_res) seq_done++;
          words_checked++;
        end
      end
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (status_q.size() != 0)
          report_error($sformatf("%0d result words never arrived", status_q.size()));
      end
    end
  end

endmodule

FILE: bench/onewire_temp_sensor_reader_unit_test.sv
// testbench top for the 1-wire temperature reader: stimulus, flow control and verdict
`timescale 1ns / 100ps

module onewire_temp_sensor_reader_unit_test;

  localparam int CycleLimit  = 500000;
  localparam int HoldCycles  = 300;
  localparam int RandPhases  = 8;
  localparam int PhaseTicks  = 20;
  localparam int StartPct    = 12;
  localparam int PartTicks   = 30;
  localparam int LongSlotTicks = 140;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_start_req = 1'b0;
  logic                          in_func = 1'b0;
  logic                          in_line_level = 1'b1;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_drive_low;
  logic                          out_busy_res;
  logic                          out_done_res;
  logic                          out_present;
  logic                          out_negative;
  logic [6:0]                    out_whole_degrees;
  logic [3:0]                    out_tenths;
  logic                          cfg_we = 1'b0;
  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [owtr_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          run_done = 1'b0;

  int mismatches;
  int words_checked;
  int seq_done;
  int ticks_sent = 0;
  int words_out = 0;
  int last_idle_word = -1;
  int cycle_cnt = 0;
  int in_idle_pct = 0;
  int stall_pct = 0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int idle_sel[4]  = '{0, 73, 0, 14};
  int stall_sel[4] = '{0, 0, 73, 14};
  int low_sel[RandPhases] = '{85, 50, 85, 85, 50, 85, 15, 85};

  onewire_temp_sensor_reader_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_func           (in_func),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_low     (out_drive_low),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_present       (out_present),
    .out_negative      (out_negative),
    .out_whole_degrees (out_whole_degrees),
    .out_tenths        (out_tenths),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  owtr_status_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_func           (in_func),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_low     (out_drive_low),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_present       (out_present),
    .out_negative      (out_negative),
    .out_whole_degrees (out_whole_degrees),
    .out_tenths        (out_tenths),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .run_done          (run_done),
    .mismatches        (mismatches),
    .words_checked     (words_checked),
    .seq_done          (seq_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (!out_busy_res) last_idle_word <= words_out;
      words_out <= words_out + 1;
    end
  end

  function automatic logic line_pick(input int low_pct);
    return ($urandom_range(99) >= low_pct);
  endfunction

  task automatic send_tick(input logic start, input logic func, input logic line);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_func       <= func;
    in_line_level <= line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait until every result word is taken
  task automatic drain_words();
    in_valid <= 1'b0;
    while (words_out != ticks_sent) @(posedge clk);
  endtask

  // feed idle ticks until the sequencer reports idle, then let the pipe empty
  task automatic settle_sequencer(input int low_pct);
    int first;
    first = ticks_sent;
    while (last_idle_word < first) send_tick(1'b0, 1'($urandom_range(1)), line_pick(low_pct));
    in_valid <= 1'b0;
    while (words_out != ticks_sent) @(posedge clk);
  endtask

  task automatic program_timing(input owtr_pkg::cfg_t t);
    logic [owtr_pkg::CfgIdxW-1:0]  idx;
    logic [owtr_pkg::CfgDataW-1:0] d;
    idx = owtr_pkg::CFG_RESET_LOW;
    repeat (owtr_pkg::CFG_SLOT - owtr_pkg::CFG_RESET_LOW + 1) begin
      case (idx)
        owtr_pkg::CFG_RESET_LOW:       d = t.reset_low_us;
        owtr_pkg::CFG_PRESENCE_SAMPLE: d = 10'(t.presence_sample_us);
        owtr_pkg::CFG_RESET_TAIL:      d = t.reset_tail_us;
        owtr_pkg::CFG_SHORT_LOW:       d = 10'(t.short_low_us);
        owtr_pkg::CFG_LONG_LOW:        d = 10'(t.long_low_us);
        owtr_pkg::CFG_READ_SAMPLE:     d = 10'(t.read_sample_us);
        default:                       d = 10'(t.slot_us);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
      idx = idx + 3'd1;
    end
    cfg_we <= 1'b0;
  endtask

  function automatic owtr_pkg::cfg_t small_timing();
    owtr_pkg::cfg_t t;
    t.reset_low_us       = 10'($urandom_range(3));
    t.presence_sample_us = 8'($urandom_range(3));
    t.reset_tail_us      = 10'($urandom_range(3));
    t.short_low_us       = 6'($urandom_range(4));
    t.long_low_us        = 7'($urandom_range(6));
    t.read_sample_us     = 7'($urandom_range(8));
    t.slot_us            = 7'($urandom_range(6));
    return t;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default timing, no device on the bus, cut short by all-zero timing
    send_tick(1'b1, 1'b0, 1'b1);
    repeat (PartTicks - 1) send_tick(1'b0, 1'b0, 1'b1);
    drain_words();
    program_timing('0);
    settle_sequencer(50);

    // all timing zero: idle word, absent device, convert with a start while busy
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    repeat (16) send_tick(1'b1, 1'b1, 1'($urandom_range(1)));
    settle_sequencer(50);

    for (int p = 0; p < RandPhases; p++) begin
      in_idle_pct = idle_sel[p % 4];
      stall_pct   = stall_sel[p % 4];
      program_timing(small_timing());
      if (p == 0) want_hold = 1'b1;
      repeat (PhaseTicks)
        send_tick($urandom_range(99) < StartPct, 1'($urandom_range(1)),
                  line_pick(low_sel[p]));
      drain_words();
      program_timing('0);
      settle_sequencer(low_sel[p]);
    end

    // reset maxima for part of a reset, then slot maxima for a full write slot
    in_idle_pct = 0;
    stall_pct   = 0;
    program_timing('{reset_low_us: 10'd1023, presence_sample_us: 8'd255,
                     reset_tail_us: 10'd1023, short_low_us: 6'd63, long_low_us: 7'd127,
                     read_sample_us: 7'd127, slot_us: 7'd127});
    send_tick(1'b1, 1'b1, 1'b1);
    repeat (PartTicks - 1) send_tick(1'b0, 1'b0, 1'b0);
    drain_words();
    program_timing('{reset_low_us: 10'd1, presence_sample_us: 8'd1, reset_tail_us: 10'd1,
                     short_low_us: 6'd63, long_low_us: 7'd127, read_sample_us: 7'd127,
                     slot_us: 7'd127});
    repeat (LongSlotTicks) send_tick(1'b0, 1'b0, 1'b0);
    drain_words();
    program_timing('0);
    settle_sequencer(50);

    repeat (4) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("run covered %0d bus ticks and %0d finished sequences, %0d result words checked",
             ticks_sent, seq_done, words_checked);
    $display("timing sets: defaults, all zero, %0d random small sets, reset and slot maxima",
             RandPhases);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
